// ===== hw/rtl/adsr_envelope_amplitude_macros.svh =====
// Assertion macros used by the checker file adsr_chk.sv.
`ifndef ADSR_ENVELOPE_AMPLITUDE_MACROS_SVH
`define ADSR_ENVELOPE_AMPLITUDE_MACROS_SVH

// Checked on every edge, reset included.
`define ADSR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

// Checked outside of reset.
`define ADSR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// ===== hw/rtl/adsr_pkg.sv =====
`timescale 1ns / 1ps

package adsr_pkg;

   localparam int LEVEL_BITS_DEFAULT = 16;
   localparam int TIME_BITS_DEFAULT  = 32;

   localparam int SEG_BITS       = 3;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [SEG_BITS-1:0] SEG_ATTACK   = 3'd0;
   localparam logic [SEG_BITS-1:0] SEG_DECAY    = 3'd1;
   localparam logic [SEG_BITS-1:0] SEG_SUSTAIN  = 3'd2;
   localparam logic [SEG_BITS-1:0] SEG_RELEASE  = 3'd3;
   localparam logic [SEG_BITS-1:0] SEG_FINISHED = 3'd4;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ATTACK_TICKS  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DECAY_TICKS   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SUSTAIN_TICKS = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RELEASE_TICKS = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PEAK_LEVEL    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SUSTAIN_LEVEL = 3'd5;

   localparam int ATTACK_TICKS_RESET  = 1000;
   localparam int DECAY_TICKS_RESET   = 1000;
   localparam int SUSTAIN_TICKS_RESET = 7000;
   localparam int RELEASE_TICKS_RESET = 1000;

   // sustain level reset = round(0.7 * full scale)
   localparam longint SUSTAIN_NUM = 7;
   localparam longint SUSTAIN_DEN = 10;

endpackage

// ===== hw/rtl/adsr_envelope_amplitude.sv =====
// Linear ADSR envelope: each beat on req_ carries a time index in ticks, and the
// matching rsp_ beat returns the amplitude in unsigned Q1.(LEVEL_BITS-1) plus the
// segment code (attack, decay, sustain, release, finished). Results come back in
// order, one per index. The pipeline takes one index every cycle when not
// stalled. Four stages locate the segment and pick the ramp operands, one
// multiplies level by elapsed ticks, and LEVEL_BITS restoring-division stages
// each resolve one quotient bit before the output register. Back-pressure on
// rsp_ready fills bubbles first, then stalls the pipe stage by stage. Registers
// are written through csr_ and read live by stages 1 to 3, so a write also
// reaches indices in those stages; level registers clamp to full scale.
`timescale 1ns / 1ps

module adsr_envelope_amplitude #(
   parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEFAULT,
   parameter int TIME_BITS  = adsr_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [TIME_BITS-1:0]                  req_time_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [LEVEL_BITS-1:0]                 rsp_amplitude,
   output logic [adsr_pkg::SEG_BITS-1:0]         rsp_segment,
   input  logic                                  csr_we,
   input  logic [adsr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [(TIME_BITS > LEVEL_BITS ? TIME_BITS : LEVEL_BITS)-1:0] csr_wdata
);

   localparam int PW   = LEVEL_BITS + TIME_BITS;
   localparam int NSTG = LEVEL_BITS + 6;
   localparam int DIV0 = 5;
   localparam logic [LEVEL_BITS-1:0] FULL_SCALE = {1'b1, {(LEVEL_BITS-1){1'b0}}};
   localparam longint FS_INT = longint'(1) << (LEVEL_BITS - 1);
   localparam logic [LEVEL_BITS-1:0] SUS_LEVEL_RESET =
      LEVEL_BITS'((FS_INT * adsr_pkg::SUSTAIN_NUM + adsr_pkg::SUSTAIN_DEN / 2)
                  / adsr_pkg::SUSTAIN_DEN);

   typedef struct packed {
      logic [PW-1:0]                 rem;
      logic [LEVEL_BITS-1:0]         q;
      logic [TIME_BITS-1:0]          dvs;
      logic [LEVEL_BITS-1:0]         base;
      logic                          sub;
      logic [adsr_pkg::SEG_BITS-1:0] seg;
   } dstage_type;

   // ---------------- registers ----------------
   logic [TIME_BITS-1:0]  attack_ff, decay_ff, sustain_ff, release_ff;
   logic [LEVEL_BITS-1:0] peak_ff, sus_lvl_ff;
   logic [LEVEL_BITS-1:0] level_wr_in;

   assign level_wr_in = (csr_wdata[LEVEL_BITS-1:0] > FULL_SCALE) ?
                        FULL_SCALE : csr_wdata[LEVEL_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= TIME_BITS'(adsr_pkg::ATTACK_TICKS_RESET);
         decay_ff   <= TIME_BITS'(adsr_pkg::DECAY_TICKS_RESET);
         sustain_ff <= TIME_BITS'(adsr_pkg::SUSTAIN_TICKS_RESET);
         release_ff <= TIME_BITS'(adsr_pkg::RELEASE_TICKS_RESET);
         peak_ff    <= FULL_SCALE;
         sus_lvl_ff <= SUS_LEVEL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            adsr_pkg::REG_ATTACK_TICKS:  attack_ff  <= csr_wdata[TIME_BITS-1:0];
            adsr_pkg::REG_DECAY_TICKS:   decay_ff   <= csr_wdata[TIME_BITS-1:0];
            adsr_pkg::REG_SUSTAIN_TICKS: sustain_ff <= csr_wdata[TIME_BITS-1:0];
            adsr_pkg::REG_RELEASE_TICKS: release_ff <= csr_wdata[TIME_BITS-1:0];
            adsr_pkg::REG_PEAK_LEVEL:    peak_ff    <= level_wr_in;
            adsr_pkg::REG_SUSTAIN_LEVEL: sus_lvl_ff <= level_wr_in;
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] adv;

   assign adv[NSTG-1] = !v_ff[NSTG-1] || rsp_ready;
   for (genvar i = 0; i < NSTG - 1; i++) begin : g_adv
      assign adv[i] = !v_ff[i] || adv[i+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (adv[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   assign req_ready = adv[0];

   // ---------------- stage 0: capture ----------------
   logic [TIME_BITS-1:0] t0_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         t0_ff <= req_time_index;
      end
   end

   // ---------------- stage 1: end of decay ----------------
   logic [TIME_BITS-1:0] t1_ff;
   logic [TIME_BITS:0]   endd1_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         t1_ff    <= t0_ff;
         endd1_ff <= {1'b0, attack_ff} + {1'b0, decay_ff};
      end
   end

   // ---------------- stage 2: end of sustain, early compares ----------------
   logic [TIME_BITS-1:0] t2_ff;
   logic [TIME_BITS+1:0] ends2_ff;
   logic                 lt_a2_ff, lt_d2_ff;
   logic [TIME_BITS-1:0] reld2_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         t2_ff    <= t1_ff;
         ends2_ff <= {1'b0, endd1_ff} + {2'b00, sustain_ff};
         lt_a2_ff <= t1_ff < attack_ff;
         lt_d2_ff <= {1'b0, t1_ff} < endd1_ff;
         reld2_ff <= t1_ff - attack_ff;
      end
   end

   // ---------------- stage 3: segment and ramp operands ----------------
   logic                          lt_s_in, fin_in;
   logic [TIME_BITS-1:0]          relr_in;
   logic [LEVEL_BITS-1:0]         mula_in, base_in;
   logic [TIME_BITS-1:0]          mulb_in, dvs_in;
   logic                          sub_in;
   logic [adsr_pkg::SEG_BITS-1:0] seg_in;

   always_comb begin
      lt_s_in = {2'b00, t2_ff} < ends2_ff;
      relr_in = t2_ff - ends2_ff[TIME_BITS-1:0];
      fin_in  = !(relr_in < release_ff);
      mula_in = '0;
      mulb_in = '0;
      dvs_in  = TIME_BITS'(1);
      base_in = '0;
      sub_in  = 1'b0;
      seg_in  = adsr_pkg::SEG_FINISHED;
      if (lt_a2_ff) begin
         mula_in = peak_ff;
         mulb_in = t2_ff;
         dvs_in  = attack_ff;
         seg_in  = adsr_pkg::SEG_ATTACK;
      end else if (lt_d2_ff) begin
         sub_in  = peak_ff >= sus_lvl_ff;
         mula_in = sub_in ? (peak_ff - sus_lvl_ff) : (sus_lvl_ff - peak_ff);
         mulb_in = reld2_ff;
         dvs_in  = decay_ff;
         base_in = peak_ff;
         seg_in  = adsr_pkg::SEG_DECAY;
      end else if (lt_s_in) begin
         base_in = sus_lvl_ff;
         seg_in  = adsr_pkg::SEG_SUSTAIN;
      end else if (!fin_in) begin
         mula_in = sus_lvl_ff;
         mulb_in = relr_in;
         dvs_in  = release_ff;
         base_in = sus_lvl_ff;
         sub_in  = 1'b1;
         seg_in  = adsr_pkg::SEG_RELEASE;
      end
   end

   logic [LEVEL_BITS-1:0]         mula3_ff, base3_ff;
   logic [TIME_BITS-1:0]          mulb3_ff, dvs3_ff;
   logic                          sub3_ff;
   logic [adsr_pkg::SEG_BITS-1:0] seg3_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         mula3_ff <= mula_in;
         mulb3_ff <= mulb_in;
         dvs3_ff  <= dvs_in;
         base3_ff <= base_in;
         sub3_ff  <= sub_in;
         seg3_ff  <= seg_in;
      end
   end

   // ---------------- stage 4: multiply; stages 5..: divide ----------------
   dstage_type dst_in [0:LEVEL_BITS];
   dstage_type dst_ff [0:LEVEL_BITS];

   always_comb begin
      dst_in[0].rem  = PW'(mula3_ff) * PW'(mulb3_ff);
      dst_in[0].q    = '0;
      dst_in[0].dvs  = dvs3_ff;
      dst_in[0].base = base3_ff;
      dst_in[0].sub  = sub3_ff;
      dst_in[0].seg  = seg3_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[DIV0-1]) begin
         dst_ff[0] <= dst_in[0];
      end
   end

   for (genvar j = 0; j < LEVEL_BITS; j++) begin : g_div
      localparam int K = LEVEL_BITS - 1 - j;
      logic [PW-1:0] dsh;
      logic          ge;

      always_comb begin
         dsh         = PW'(dst_ff[j].dvs) << K;
         ge          = dst_ff[j].rem >= dsh;
         dst_in[j+1] = dst_ff[j];
         if (ge) begin
            dst_in[j+1].rem  = dst_ff[j].rem - dsh;
            dst_in[j+1].q[K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[DIV0+j]) begin
            dst_ff[j+1] <= dst_in[j+1];
         end
      end
   end

   // ---------------- output stage ----------------
   logic [LEVEL_BITS-1:0]         amp_in, amp_ff;
   logic [adsr_pkg::SEG_BITS-1:0] seg_ff;

   assign amp_in = dst_ff[LEVEL_BITS].sub ?
                   dst_ff[LEVEL_BITS].base - dst_ff[LEVEL_BITS].q :
                   dst_ff[LEVEL_BITS].base + dst_ff[LEVEL_BITS].q;

   always_ff @(posedge clock) begin
      if (adv[NSTG-1]) begin
         amp_ff <= amp_in;
         seg_ff <= dst_ff[LEVEL_BITS].seg;
      end
   end

   assign rsp_valid     = v_ff[NSTG-1];
   assign rsp_amplitude = amp_ff;
   assign rsp_segment   = seg_ff;

endmodule

// ===== hw/rtl/adsr_chk.sv =====
`timescale 1ns / 1ps
`include "adsr_envelope_amplitude_macros.svh"

module adsr_chk #(
   parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [LEVEL_BITS-1:0]         rsp_amplitude,
   input logic [adsr_pkg::SEG_BITS-1:0] rsp_segment
);

   localparam logic [LEVEL_BITS-1:0] FULL_SCALE = {1'b1, {(LEVEL_BITS-1){1'b0}}};

   logic                                   fin_beat, att_beat, stalled;
   logic [LEVEL_BITS+adsr_pkg::SEG_BITS-1:0] rsp_payload;

   assign fin_beat    = rsp_valid && (rsp_segment == adsr_pkg::SEG_FINISHED);
   assign att_beat    = rsp_valid && (rsp_segment == adsr_pkg::SEG_ATTACK);
   assign stalled     = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_amplitude, rsp_segment};

   `ADSR_ASSERT_ALWAYS(a_no_beat_after_reset, reset |=> !rsp_valid, "rsp beat right after reset")

   `ADSR_ASSERT(a_amp_range, rsp_valid |-> rsp_amplitude <= FULL_SCALE, "amplitude above full scale")

   `ADSR_ASSERT(a_finished_zero, fin_beat |-> rsp_amplitude == '0, "finished with nonzero amplitude")

   `ADSR_ASSERT(a_attack_below_fs, att_beat |-> rsp_amplitude < FULL_SCALE, "attack reached full scale")

   `ADSR_ASSERT(a_rsp_hold, stalled |=> rsp_valid && $stable(rsp_payload), "stalled rsp beat changed")

endmodule

bind adsr_envelope_amplitude adsr_chk #(.LEVEL_BITS(LEVEL_BITS)) u_adsr_chk (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int LEVEL_W = adsr_pkg::LEVEL_BITS_DEFAULT;
   localparam int TIME_W  = adsr_pkg::TIME_BITS_DEFAULT;
   localparam int SEG_W   = adsr_pkg::SEG_BITS;
   localparam int IDX_W   = adsr_pkg::CSR_INDEX_BITS;
   localparam int CSR_W   = (TIME_W > LEVEL_W) ? TIME_W : LEVEL_W;
   localparam longint unsigned FULL_SCALE = 64'd1 << (LEVEL_W - 1);
   localparam longint unsigned TIME_MAX   = (64'd1 << TIME_W) - 1;
   localparam int PIPE_LATENCY    = LEVEL_W + 6;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int PHASES          = 9;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int HOLD_CYCLES     = 120;
   localparam int N_ROWS          = 36;

   typedef struct {
      logic [TIME_W-1:0]  time_index;
      logic [LEVEL_W-1:0] amplitude;
      logic [SEG_W-1:0]   segment;
   } envelope_point_type;

   typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [IDX_W-1:0]   reg_index;
      logic [31:0]        value;
      logic [LEVEL_W-1:0] amplitude;
      logic [SEG_W-1:0]   segment;
   } directed_row_type;

   // item rows carry the time index in value
   localparam directed_row_type DIRECTED_ROWS [N_ROWS] = '{
      '{ROW_TYPED,   '0, 32'd0,         16'd0,     adsr_pkg::SEG_ATTACK},
      '{ROW_PREDICT, '0, 32'd1,         16'd0,     adsr_pkg::SEG_ATTACK},
      '{ROW_PREDICT, '0, 32'd999,       16'd0,     adsr_pkg::SEG_ATTACK},
      '{ROW_TYPED,   '0, 32'd1000,      16'd32768, adsr_pkg::SEG_DECAY},
      '{ROW_PREDICT, '0, 32'd1999,      16'd0,     adsr_pkg::SEG_ATTACK},
      '{ROW_TYPED,   '0, 32'd2000,      16'd22938, adsr_pkg::SEG_SUSTAIN},
      '{ROW_TYPED,   '0, 32'd8999,      16'd22938, adsr_pkg::SEG_SUSTAIN},
      '{ROW_TYPED,   '0, 32'd9000,      16'd22938, adsr_pkg::SEG_RELEASE},
      '{ROW_PREDICT, '0, 32'd9999,      16'd0,     adsr_pkg::SEG_ATTACK},
      '{ROW_TYPED,   '0, 32'd10000,     16'd0,     adsr_pkg::SEG_FINISHED},
      '{ROW_TYPED,   '0, 32'hFFFF_FFFF, 16'd0,     adsr_pkg::SEG_FINISHED},
      '{ROW_WRITE, adsr_pkg::REG_PEAK_LEVEL,    32'h0000_FFFF, 16'd0, adsr_pkg::SEG_ATTACK},
      '{ROW_WRITE, adsr_pkg::REG_SUSTAIN_LEVEL, 32'd40000,     16'd0, adsr_pkg::SEG_ATTACK},
      '{ROW_TYPED,   '0, 32'd1500,      16'd32768, adsr_pkg::SEG_DECAY},
      '{ROW_WRITE, adsr_pkg::REG_ATTACK_TICKS,  32'd0,         16'd0, adsr_pkg::SEG_ATTACK},
      '{ROW_WRITE, adsr_pkg::REG_PEAK_LEVEL,    32'd1000,      16'd0, adsr_pkg::SEG_ATTACK},
      '{ROW_WRITE, adsr_pkg::REG_SUSTAIN_LEVEL, 32'd30000,     16'd0, adsr_pkg::SEG_ATTACK},
      '{ROW_TYPED,   '0, 32'd0,         16'd1000,  adsr_pkg::SEG_DECAY},
      '{ROW_PREDICT, '0, 32'd999,       16'd0,     adsr_pkg::SEG_ATTACK},
      '{ROW_TYPED,   '0, 32'd1000,      16'd30000, adsr_pkg::SEG_SUSTAIN},
      '{ROW_WRITE, adsr_pkg::REG_DECAY_TICKS,   32'd0,         16'd0, adsr_pkg::SEG_ATTACK},
      '{ROW_TYPED,   '0, 32'd0,         16'd30000, adsr_pkg::SEG_SUSTAIN},
      '{ROW_WRITE, adsr_pkg::REG_RELEASE_TICKS, 32'd0,         16'd0, adsr_pkg::SEG_ATTACK},
      '{ROW_TYPED,   '0, 32'd7000,      16'd0,     adsr_pkg::SEG_FINISHED},
      '{ROW_TYPED,   '0, 32'd6999,      16'd30000, adsr_pkg::SEG_SUSTAIN},
      '{ROW_WRITE, adsr_pkg::REG_ATTACK_TICKS,  32'hFFFF_FFFF, 16'd0, adsr_pkg::SEG_ATTACK},
      '{ROW_WRITE, adsr_pkg::REG_DECAY_TICKS,   32'hFFFF_FFFF, 16'd0, adsr_pkg::SEG_ATTACK},
      '{ROW_WRITE, adsr_pkg::REG_SUSTAIN_TICKS, 32'hFFFF_FFFF, 16'd0, adsr_pkg::SEG_ATTACK},
      '{ROW_WRITE, adsr_pkg::REG_RELEASE_TICKS, 32'hFFFF_FFFF, 16'd0, adsr_pkg::SEG_ATTACK},
      '{ROW_WRITE, adsr_pkg::REG_PEAK_LEVEL,    32'd32768,     16'd0, adsr_pkg::SEG_ATTACK},
      '{ROW_WRITE, adsr_pkg::REG_SUSTAIN_LEVEL, 32'd0,         16'd0, adsr_pkg::SEG_ATTACK},
      '{ROW_TYPED,   '0, 32'hFFFF_FFFF, 16'd32768, adsr_pkg::SEG_DECAY},
      '{ROW_PREDICT, '0, 32'hFFFF_FFFE, 16'd0,     adsr_pkg::SEG_ATTACK},
      '{ROW_TYPED,   '0, 32'd0,         16'd0,     adsr_pkg::SEG_ATTACK},
      '{ROW_WRITE, adsr_pkg::REG_PEAK_LEVEL,    32'h0001_2345, 16'd0, adsr_pkg::SEG_ATTACK},
      '{ROW_PREDICT, '0, 32'h8000_0000, 16'd0,     adsr_pkg::SEG_ATTACK}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [TIME_W-1:0]   req_time_index = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [LEVEL_W-1:0]  rsp_amplitude;
   logic [SEG_W-1:0]    rsp_segment;
   logic                csr_we = 1'b0;
   logic [IDX_W-1:0]    csr_index = '0;
   logic [CSR_W-1:0]    csr_wdata = '0;

   logic [TIME_W-1:0]  attack_ticks  = TIME_W'(adsr_pkg::ATTACK_TICKS_RESET);
   logic [TIME_W-1:0]  decay_ticks   = TIME_W'(adsr_pkg::DECAY_TICKS_RESET);
   logic [TIME_W-1:0]  sustain_ticks = TIME_W'(adsr_pkg::SUSTAIN_TICKS_RESET);
   logic [TIME_W-1:0]  release_ticks = TIME_W'(adsr_pkg::RELEASE_TICKS_RESET);
   logic [LEVEL_W-1:0] peak_level    = LEVEL_W'(FULL_SCALE);
   logic [LEVEL_W-1:0] sustain_level =
      LEVEL_W'((FULL_SCALE * adsr_pkg::SUSTAIN_NUM + adsr_pkg::SUSTAIN_DEN / 2)
               / adsr_pkg::SUSTAIN_DEN);

   envelope_point_type points_in_flight [$];
   int mismatches   = 0;
   int cycle_count  = 0;
   int holds_asked  = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;

   adsr_envelope_amplitude u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_time_index (req_time_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_amplitude  (rsp_amplitude),
      .rsp_segment    (rsp_segment),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // multiply first, truncate the quotient
   function automatic longint unsigned ramp(input longint unsigned level,
                                            input longint unsigned elapsed,
                                            input longint unsigned span);
      return (level * elapsed) / span;
   endfunction

   function automatic envelope_point_type envelope_at(input logic [TIME_W-1:0] t);
      longint unsigned end_attack, end_decay, end_sustain, rel, amp;
      envelope_point_type p;
      end_attack  = attack_ticks;
      end_decay   = end_attack + decay_ticks;
      end_sustain = end_decay + sustain_ticks;
      p.time_index = t;
      if (t < end_attack) begin
         amp = ramp(peak_level, t, attack_ticks);
         p.segment = adsr_pkg::SEG_ATTACK;
      end else if (t < end_decay) begin
         rel = t - end_attack;
         if (peak_level >= sustain_level) begin
            amp = peak_level - ramp(peak_level - sustain_level, rel, decay_ticks);
         end else begin
            amp = peak_level + ramp(sustain_level - peak_level, rel, decay_ticks);
         end
         p.segment = adsr_pkg::SEG_DECAY;
      end else if (t < end_sustain) begin
         amp = sustain_level;
         p.segment = adsr_pkg::SEG_SUSTAIN;
      end else begin
         rel = t - end_sustain;
         if (rel < release_ticks) begin
            amp = sustain_level - ramp(sustain_level, rel, release_ticks);
            p.segment = adsr_pkg::SEG_RELEASE;
         end else begin
            amp = 0;
            p.segment = adsr_pkg::SEG_FINISHED;
         end
      end
      p.amplitude = amp[LEVEL_W-1:0];
      return p;
   endfunction

   function automatic logic [TIME_W-1:0] pick_ticks();
      case ($urandom_range(0, 19))
         0, 1:    return '0;
         2:       return '1;
         3:       return TIME_W'($urandom);
         4, 5, 6, 7, 8: return TIME_W'($urandom_range(1, 8));
         default: return TIME_W'($urandom_range(1, 400));
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] pick_level();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CSR_W'(FULL_SCALE);
         2:       return CSR_W'($urandom_range(32'(FULL_SCALE + 1),
                                               32'((64'd1 << LEVEL_W) - 1)));
         3:       return CSR_W'($urandom);
         default: return CSR_W'($urandom_range(0, 32'(FULL_SCALE)));
      endcase
   endfunction

   // mostly inside the envelope, some near segment edges, some anywhere
   function automatic logic [TIME_W-1:0] pick_index();
      longint unsigned edges [4];
      longint unsigned total, b;
      edges[0] = attack_ticks;
      edges[1] = edges[0] + decay_ticks;
      edges[2] = edges[1] + sustain_ticks;
      edges[3] = edges[2] + release_ticks;
      total = edges[3];
      case ($urandom_range(0, 7))
         0: return TIME_W'($urandom);
         1, 2: begin
            b = edges[$urandom_range(0, 3)] + $urandom_range(0, 2);
            if (b == 0) return '0;
            return (b - 1 > TIME_MAX) ? TIME_W'(TIME_MAX) : TIME_W'(b - 1);
         end
         default: begin
            if (total < 64'h8000_0000)
               return TIME_W'($urandom_range(0, 32'(total + total / 8 + 2)));
            return TIME_W'($urandom);
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [TIME_W-1:0] t,
                                  input longint unsigned got, input longint unsigned want);
      $display("mismatch: %s at time index %0d: got %0d, expected %0d", what, t, got, want);
      mismatches++;
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx,
                            input logic [CSR_W-1:0] value);
      logic [LEVEL_W-1:0] lvl;
      lvl = value[LEVEL_W-1:0];
      if (lvl > FULL_SCALE) lvl = LEVEL_W'(FULL_SCALE);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         adsr_pkg::REG_ATTACK_TICKS:  attack_ticks  = value[TIME_W-1:0];
         adsr_pkg::REG_DECAY_TICKS:   decay_ticks   = value[TIME_W-1:0];
         adsr_pkg::REG_SUSTAIN_TICKS: sustain_ticks = value[TIME_W-1:0];
         adsr_pkg::REG_RELEASE_TICKS: release_ticks = value[TIME_W-1:0];
         adsr_pkg::REG_PEAK_LEVEL:    peak_level    = lvl;
         adsr_pkg::REG_SUSTAIN_LEVEL: sustain_level = lvl;
         default: ;
      endcase
   endtask

   // one beat on req_; returns right after the accepting edge
   task automatic offer_index(input logic [TIME_W-1:0] t, input bit typed,
                              input logic [LEVEL_W-1:0] amp, input logic [SEG_W-1:0] seg);
      envelope_point_type want;
      want = envelope_at(t);
      if (typed) begin
         want.amplitude = amp;
         want.segment   = seg;
      end
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_time_index <= t;
      do @(posedge clock); while (!req_ready);
      points_in_flight.push_back(want);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (points_in_flight.size() != 0) @(posedge clock);
   endtask

   initial begin : rsp_side
      int holds_served;
      holds_served = 0;
      forever begin
         @(negedge clock);
         if (holds_served < holds_asked) begin
            holds_served++;
            repeat (HOLD_CYCLES) begin
               rsp_ready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      envelope_point_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (points_in_flight.size() == 0) begin
            report_mismatch("beat with nothing pending", '0, rsp_amplitude, 0);
         end else begin
            want = points_in_flight.pop_front();
            if (rsp_amplitude !== want.amplitude)
               report_mismatch("amplitude", want.time_index, rsp_amplitude, want.amplitude);
            if (rsp_segment !== want.segment)
               report_mismatch("segment", want.time_index, rsp_segment, want.segment);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      directed_row_type row;
      int phase, n, r;
      req_idle_pct = 22;
      rsp_idle_pct = 75;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (r = 0; r < N_ROWS; r++) begin
         row = DIRECTED_ROWS[r];
         if (row.kind == ROW_WRITE) begin
            wait_idle();
            write_reg(row.reg_index, row.value);
         end else begin
            offer_index(row.value, row.kind == ROW_TYPED, row.amplitude, row.segment);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         if (phase < 3) begin
            req_idle_pct = 22;
            rsp_idle_pct = 75;
         end else if (phase < 6) begin
            req_idle_pct = 75;
            rsp_idle_pct = 22;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         write_reg(adsr_pkg::REG_ATTACK_TICKS, pick_ticks());
         write_reg(adsr_pkg::REG_DECAY_TICKS, pick_ticks());
         write_reg(adsr_pkg::REG_SUSTAIN_TICKS, pick_ticks());
         write_reg(adsr_pkg::REG_RELEASE_TICKS, pick_ticks());
         write_reg(adsr_pkg::REG_PEAK_LEVEL, pick_level());
         write_reg(adsr_pkg::REG_SUSTAIN_LEVEL, pick_level());
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // long receiver hold-off to back the pipe up into req_ready
            if (phase == 6 && n == 5) holds_asked++;
            if (phase == 7 && n == 25) wait_idle();
            offer_index(pick_index(), 1'b0, '0, adsr_pkg::SEG_ATTACK);
         end
      end

      wait_idle();
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
